/* src/color_dominance_threshold_unit_defines.svh */
// Assertion macros shared by the color dominance threshold unit.
`ifndef COLOR_DOMINANCE_THRESHOLD_UNIT_DEFINES_SVH
`define COLOR_DOMINANCE_THRESHOLD_UNIT_DEFINES_SVH

// Checks that a condition at one edge implies a consequent at the same edge.
`define CDT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdt check failed");

// Checks that a condition at one edge implies a consequent at the next edge.
`define CDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdt check failed");

`endif

/* src/cdt_pkg.sv */
// Package with shared types and constants of the color dominance threshold unit.
package cdt_pkg;

	localparam int unsigned PixW    = 8;
	localparam int unsigned PeriodW = 7;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 8;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_COLOR_MODE   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DOM_MARGIN   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PEAK_MARGIN  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_LEVEL_OFFSET = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_REFRESH_PER  = 3'd4;

	// Color modes
	localparam logic MODE_RED  = 1'b0;
	localparam logic MODE_BLUE = 1'b1;

	// Reset values of the configuration registers
	localparam logic [PixW-1:0]    DOM_MARGIN_RST  = 8'd30;
	localparam logic [PixW-1:0]    PEAK_MARGIN_RST = 8'd200;
	localparam logic [PixW-1:0]    LEVEL_OFS_RST   = 8'd0;
	localparam logic [PeriodW-1:0] PERIOD_RST      = 7'd32;
	localparam logic [PeriodW-1:0] PERIOD_MIN      = 7'd1;
	localparam logic [PeriodW-1:0] PERIOD_MAX      = 7'd64;

	// Per-pixel evaluation result
	typedef struct packed {
		logic            mark;
		logic            peak_cand;
		logic [PixW-1:0] chosen;
	} cdt_eval_t;

	// Tracker status seen by the evaluator and the checks
	typedef struct packed {
		logic [PixW-1:0] level;
		logic            refresh;
		logic            peak_nz;
	} cdt_track_t;

endpackage

/* src/cdt_ifs.sv */
// Valid/ready channel interfaces for pixel input words and mask output words.
interface cdt_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue_value;
	logic [7:0] green_value;
	logic [7:0] red_value;
	logic       frame_end;

	modport source (output valid, blue_value, green_value, red_value, frame_end,
		input ready);
	modport sink (input valid, blue_value, green_value, red_value, frame_end,
		output ready);
endinterface

interface cdt_mask_if;
	logic valid;
	logic ready;
	logic mask_bit;
	logic frame_last;

	modport source (output valid, mask_bit, frame_last, input ready);
	modport sink (input valid, mask_bit, frame_last, output ready);
endinterface

/* src/cdt_eval.sv */
// Per-pixel dominance compare against the marking and peak margins.
module cdt_eval
	import cdt_pkg::*;
(
	input  logic [PixW-1:0] blue_value,
	input  logic [PixW-1:0] green_value,
	input  logic [PixW-1:0] red_value,
	input  logic            mode,
	input  logic [PixW-1:0] dom_margin,
	input  logic [PixW-1:0] peak_margin,
	input  logic [PixW-1:0] level,
	output cdt_eval_t       res
);
	logic [PixW-1:0] chosen;
	logic [PixW-1:0] other;
	logic [PixW:0]   g_dom, o_dom, lvl_dom, g_peak, o_peak;
	logic [PixW:0]   c_ext;

	// pick the chosen color and the non-green competitor
	assign chosen = (mode == MODE_BLUE) ? blue_value : red_value;
	assign other  = (mode == MODE_BLUE) ? red_value : blue_value;
	assign c_ext  = {1'b0, chosen};

	// c - m > x  is  c > x + m, done without wrap in 9 bits
	assign g_dom   = {1'b0, green_value} + {1'b0, dom_margin};
	assign o_dom   = {1'b0, other} + {1'b0, dom_margin};
	assign lvl_dom = {1'b0, level} + {1'b0, dom_margin};
	assign g_peak  = {1'b0, green_value} + {1'b0, peak_margin};
	assign o_peak  = {1'b0, other} + {1'b0, peak_margin};

	always_comb begin
		res.chosen    = chosen;
		res.mark      = (c_ext > g_dom) && (c_ext > o_dom) && (c_ext >= lvl_dom);
		res.peak_cand = (c_ext > g_peak) && (c_ext > o_peak);
	end
endmodule

/* src/cdt_track.sv */
// Frame counter, peak tracking and per-mode adaptive level registers.
module cdt_track
	import cdt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               frame_end,
	input  cdt_eval_t          ev,
	input  logic               mode,
	input  logic [PixW-1:0]    level_offset,
	input  logic [PeriodW-1:0] refresh_period,
	output cdt_track_t         stat
);
	logic [PixW-1:0]    level_q [2];
	logic [PixW-1:0]    frame_peak_q;
	logic [PeriodW-1:0] frame_count_q;
	logic               refresh_q;

	logic [PeriodW-1:0] period;
	logic [PeriodW:0]   cnt_inc;
	logic [PeriodW-1:0] cnt_next;
	logic [PixW-1:0]    peak_next;
	logic               peak_upd;

	// clamp the period to 1..64
	always_comb begin
		period = refresh_period;
		if (refresh_period < PERIOD_MIN) period = PERIOD_MIN;
		if (refresh_period > PERIOD_MAX) period = PERIOD_MAX;
	end

	// next frame count, wrapping at the period
	assign cnt_inc  = {1'b0, frame_count_q} + {{PeriodW{1'b0}}, 1'b1};
	assign cnt_next = (cnt_inc >= {1'b0, period}) ? '0 : cnt_inc[PeriodW-1:0];

	// running peak over strongly dominant pixels in a tracking frame
	assign peak_upd  = refresh_q && ev.peak_cand && (ev.chosen >= frame_peak_q);
	assign peak_next = peak_upd ? ev.chosen : frame_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q[0]    <= '0;
			level_q[1]    <= '0;
			frame_peak_q  <= '0;
			frame_count_q <= '0;
			refresh_q     <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				if (refresh_q) level_q[mode] <= peak_next - level_offset;
				frame_peak_q  <= '0;
				frame_count_q <= cnt_next;
				refresh_q     <= (cnt_next == (period - PERIOD_MIN));
			end else begin
				frame_peak_q <= peak_next;
			end
		end
	end

	always_comb begin
		stat.level   = level_q[mode];
		stat.refresh = refresh_q;
		stat.peak_nz = (frame_peak_q != '0);
	end
endmodule

/* src/color_dominance_threshold_unit.sv */
// Top level of the color dominance threshold unit.
// Marks BGR pixels whose chosen color (red or blue) beats both other components
// by the dominance margin and, less that margin, reaches that mode's adaptive
// level; one mask word leaves for every pixel word, in order. Each word is
// held in the input register and is evaluated and committed to the tracking
// state on its way into the output register, so the unit sustains one word per
// clock while the output is ready; a stalled output backs up through the two
// registers. Every refresh_period frames a tracking frame records the peak of
// strongly dominant pixels, and the level of the current mode becomes peak minus
// level_offset from the next frame on. Configuration writes go through
// cfg_we/cfg_index/cfg_data and must only happen while no word is in flight.
`include "color_dominance_threshold_unit_defines.svh"

module color_dominance_threshold_unit
	import cdt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	cdt_pixel_if.sink           pix,
	cdt_mask_if.source          mask,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);
	logic               color_mode_q;
	logic [PixW-1:0]    dom_margin_q;
	logic [PixW-1:0]    peak_margin_q;
	logic [PixW-1:0]    level_offset_q;
	logic [PeriodW-1:0] refresh_period_q;

	logic            valid_s1;
	logic [PixW-1:0] blue_s1, green_s1, red_s1;
	logic            fe_s1;
	logic            valid_s2, mask_s2, fe_s2;

	logic       advance;
	cdt_eval_t  ev;
	cdt_track_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q     <= MODE_RED;
			dom_margin_q     <= DOM_MARGIN_RST;
			peak_margin_q    <= PEAK_MARGIN_RST;
			level_offset_q   <= LEVEL_OFS_RST;
			refresh_period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLOR_MODE:   color_mode_q     <= cfg_data[0];
				CFG_DOM_MARGIN:   dom_margin_q     <= cfg_data;
				CFG_PEAK_MARGIN:  peak_margin_q    <= cfg_data;
				CFG_LEVEL_OFFSET: level_offset_q   <= cfg_data;
				CFG_REFRESH_PER:  refresh_period_q <= cfg_data[PeriodW-1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves to s2 when s2 is empty or being drained
	assign advance   = valid_s1 && (!valid_s2 || mask.ready);
	assign pix.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			blue_s1  <= pix.blue_value;
			green_s1 <= pix.green_value;
			red_s1   <= pix.red_value;
			fe_s1    <= pix.frame_end;
		end
	end

	cdt_eval u_eval (
		.blue_value  (blue_s1),
		.green_value (green_s1),
		.red_value   (red_s1),
		.mode        (color_mode_q),
		.dom_margin  (dom_margin_q),
		.peak_margin (peak_margin_q),
		.level       (stat.level),
		.res         (ev)
	);

	cdt_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.frame_end      (fe_s1),
		.ev             (ev),
		.mode           (color_mode_q),
		.level_offset   (level_offset_q),
		.refresh_period (refresh_period_q),
		.stat           (stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (mask.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_s2 <= ev.mark;
			fe_s2   <= fe_s1;
		end
	end

	assign mask.valid      = valid_s2;
	assign mask.mask_bit   = mask_s2;
	assign mask.frame_last = fe_s2;

	// checks
	`CDT_ASSERT_SAME(a_stall_blocks_input, valid_s1 && valid_s2 && !mask.ready, !pix.ready)
	`CDT_ASSERT_SAME(a_peak_only_tracking, stat.peak_nz, stat.refresh)
	`CDT_ASSERT_NEXT(a_result_from_advance, !valid_s2 && !advance, !mask.valid)
endmodule

/* tb/testbench.sv */
// Self-checking testbench of the color dominance threshold unit with its own mask predictor.
`timescale 1ns / 1ps

module testbench;
	import cdt_pkg::*;

	localparam int IdlePct      = 37;
	localparam int NumPhases    = 10;
	localparam int PhaseItems   = 104;
	localparam int ShowFailures = 10;

	typedef struct packed {
		logic [PixW-1:0] blue;
		logic [PixW-1:0] green;
		logic [PixW-1:0] red;
		logic            frame_end;
	} pixel_word_t;

	typedef struct packed {
		logic mask_bit;
		logic frame_last;
	} mask_word_t;

	typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

	// One line of the directed stimulus: a pixel word or a register write
	typedef struct {
		row_kind_t           kind;
		logic [CfgIdxW-1:0]  reg_idx;
		logic [CfgDataW-1:0] reg_val;
		pixel_word_t         px;
		bit                  fixed;
		logic                fixed_mask;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cdt_pixel_if pix_ch ();
	cdt_mask_if  mask_ch ();

	color_dominance_threshold_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.mask      (mask_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor copy of the registers and the tracking state
	logic                mode_q;
	logic [PixW-1:0]     dom_margin_q;
	logic [PixW-1:0]     peak_margin_q;
	logic [PixW-1:0]     level_ofs_q;
	logic [PeriodW-1:0]  period_q;
	logic [PixW-1:0]     level_q [2];
	logic [PixW-1:0]     peak_q;
	logic [PeriodW-1:0]  frame_cnt_q;
	logic                tracking_q;

	mask_word_t pending_masks [$];
	mask_word_t oldest_mask;
	int  fail_cnt = 0;
	bit  calm = 1'b0;

	task automatic note_failure(input string msg);
		if (fail_cnt < ShowFailures)
			$display("%0t ns: %s", $time, msg);
		fail_cnt++;
	endtask

	function automatic void store_config(input logic [CfgIdxW-1:0] idx,
		input logic [CfgDataW-1:0] val);
		case (idx)
			CFG_COLOR_MODE:   mode_q = val[0];
			CFG_DOM_MARGIN:   dom_margin_q = val;
			CFG_PEAK_MARGIN:  peak_margin_q = val;
			CFG_LEVEL_OFFSET: level_ofs_q = val;
			CFG_REFRESH_PER:  period_q = val[PeriodW-1:0];
			default: ;
		endcase
	endfunction

	// Mask of one pixel word; advances peak, level and frame tracking
	function automatic mask_word_t predict_mask(input pixel_word_t px);
		int chosen, other_a, other_b, lim, strong_lim;
		int unsigned per, cnt;
		logic m;
		mask_word_t res;
		m = mode_q;
		chosen  = m ? px.blue : px.red;
		other_a = px.green;
		other_b = m ? px.red : px.blue;
		lim = chosen - int'(dom_margin_q);
		res.mask_bit = (other_a < lim) && (other_b < lim) && (lim >= int'(level_q[m]));
		if (tracking_q) begin
			strong_lim = chosen - int'(peak_margin_q);
			if (chosen >= int'(peak_q) && strong_lim > other_a && strong_lim > other_b)
				peak_q = chosen[PixW-1:0];
		end
		if (px.frame_end) begin
			per = period_q;
			if (per < 1) per = 1;
			if (per > 64) per = 64;
			// level of the mode in force at frame end; applies from next frame
			if (tracking_q)
				level_q[m] = peak_q - level_ofs_q;
			peak_q = '0;
			cnt = frame_cnt_q + 1;
			if (cnt >= per) cnt = 0;
			frame_cnt_q = cnt[PeriodW-1:0];
			tracking_q = (cnt == per - 1);
		end
		res.frame_last = px.frame_end;
		return res;
	endfunction

	// Register write while idle: drain all masks first
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		pix_ch.valid <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		store_config(idx, val);
	endtask

	// Offer one pixel word; returns in the step of the accepting edge
	task automatic send_pixel(input pixel_word_t px, input bit fixed, input logic fixed_mask);
		mask_word_t want;
		while (!calm && $urandom_range(0, 99) < IdlePct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.blue_value  <= px.blue;
		pix_ch.green_value <= px.green;
		pix_ch.red_value   <= px.red;
		pix_ch.frame_end   <= px.frame_end;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		want = predict_mask(px);
		if (fixed)
			want.mask_bit = fixed_mask;
		pending_masks = {pending_masks, want};
	endtask

	function automatic dir_row_t pix_row(input int b, input int g, input int r, input bit fe);
		dir_row_t row;
		row = '{kind: ROW_PIXEL, reg_idx: '0, reg_val: '0, px: '0, fixed: 1'b0,
			fixed_mask: 1'b0};
		row.px = '{blue: b[7:0], green: g[7:0], red: r[7:0], frame_end: fe};
		return row;
	endfunction

	function automatic dir_row_t fixed_row(input int b, input int g, input int r, input bit fe,
		input logic m);
		dir_row_t row;
		row = pix_row(b, g, r, fe);
		row.fixed = 1'b1;
		row.fixed_mask = m;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx, input int val);
		dir_row_t row;
		row = pix_row(0, 0, 0, 1'b0);
		row.kind = ROW_CONFIG;
		row.reg_idx = idx;
		row.reg_val = val[CfgDataW-1:0];
		return row;
	endfunction

	// Random margin or offset, often at an extreme
	function automatic logic [CfgDataW-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 12));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CfgDataW-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd64;
			2: return 8'($urandom_range(65, 127));
			3, 4, 5, 6: return 8'($urandom_range(1, 4));
			default: return 8'($urandom_range(1, 64));
		endcase
	endfunction

	// Mostly pixels dominant in some color, the rest fully random
	function automatic pixel_word_t rand_pixel(input int unsigned fe_pct);
		int unsigned shape, c, oa, ob;
		logic side;
		pixel_word_t px;
		shape = $urandom_range(0, 9);
		side = (shape == 9) ? !mode_q : mode_q;
		if (shape < 3) begin
			px = pixel_word_t'($urandom());
		end else begin
			if (shape >= 7) begin
				c  = $urandom_range(200, 255);
				oa = $urandom_range(0, 24);
				ob = $urandom_range(0, 24);
			end else begin
				c  = $urandom_range(0, 255);
				oa = $urandom_range(0, c >> $urandom_range(0, 3));
				ob = $urandom_range(0, c >> $urandom_range(0, 3));
			end
			px.green = oa[7:0];
			px.blue  = side ? c[7:0] : ob[7:0];
			px.red   = side ? ob[7:0] : c[7:0];
		end
		px.frame_end = ($urandom_range(0, 99) < fe_pct);
		return px;
	endfunction

	// Output side: random stalls, compare each mask word with the oldest one due
	always @(posedge clk) begin
		if (!arst_n) begin
			mask_ch.ready <= 1'b0;
		end else begin
			if (mask_ch.valid && mask_ch.ready) begin
				if (pending_masks.size() == 0) begin
					note_failure($sformatf("unexpected mask word mask_bit=%b frame_last=%b",
						mask_ch.mask_bit, mask_ch.frame_last));
				end else begin
					oldest_mask = pending_masks.pop_front();
					if (mask_ch.mask_bit !== oldest_mask.mask_bit ||
						mask_ch.frame_last !== oldest_mask.frame_last)
						note_failure($sformatf(
							"mask mismatch: expected mask_bit=%b frame_last=%b, got %b %b",
							oldest_mask.mask_bit, oldest_mask.frame_last,
							mask_ch.mask_bit, mask_ch.frame_last));
				end
			end
			mask_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
		end
	end

	// Hard stop if the flow hangs
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus
	initial begin
		dir_row_t dir_rows [$];
		int unsigned fe_pct;
		pixel_word_t px;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.blue_value <= '0;
		pix_ch.green_value <= '0;
		pix_ch.red_value <= '0;
		pix_ch.frame_end <= 1'b0;

		mode_q = MODE_RED;
		dom_margin_q = DOM_MARGIN_RST;
		peak_margin_q = PEAK_MARGIN_RST;
		level_ofs_q = LEVEL_OFS_RST;
		period_q = PERIOD_RST;
		level_q[0] = '0;
		level_q[1] = '0;
		peak_q = '0;
		frame_cnt_q = '0;
		tracking_q = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, margin above color, per-mode level, period corners
		dir_rows = '{
			cfg_row(CFG_REFRESH_PER, 2),        // first tracking frame is frame 1
			fixed_row(0, 0, 255, 1'b0, 1'b1),
			fixed_row(0, 0, 0, 1'b0, 1'b0),     // margin above color, no wrap
			fixed_row(255, 255, 255, 1'b1, 1'b0),
			fixed_row(0, 0, 30, 1'b0, 1'b0),
			fixed_row(0, 0, 31, 1'b1, 1'b1),
			cfg_row(CFG_REFRESH_PER, 1),
			pix_row(0, 0, 255, 1'b1),
			pix_row(0, 0, 255, 1'b0),
			pix_row(10, 20, 240, 1'b1),         // level of red set from the peak
			pix_row(0, 0, 255, 1'b0),
			cfg_row(CFG_LEVEL_OFFSET, 250),
			pix_row(0, 0, 255, 1'b1),
			cfg_row(CFG_COLOR_MODE, MODE_BLUE),
			pix_row(255, 0, 0, 1'b0),           // blue keeps its own level
			cfg_row(CFG_COLOR_MODE, MODE_RED),  // mode change inside the frame
			pix_row(0, 0, 100, 1'b1),
			cfg_row(CFG_PEAK_MARGIN, 255),
			pix_row(0, 0, 255, 1'b1),           // empty peak, level wraps
			cfg_row(CFG_DOM_MARGIN, 0),
			pix_row(0, 0, 7, 1'b0),
			pix_row(0, 0, 0, 1'b0),
			cfg_row(CFG_REFRESH_PER, 0),        // zero period acts as one
			pix_row(0, 0, 255, 1'b1),
			cfg_row(CFG_REFRESH_PER, 127),      // oversize period clamps
			cfg_row(3'd7, 255),                 // unknown index is ignored
			pix_row(255, 255, 0, 1'b1)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CONFIG)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else
				send_pixel(dir_rows[i].px, dir_rows[i].fixed, dir_rows[i].fixed_mask);
		end

		// Random phases, each with a fresh register setting
		for (int ph = 0; ph < NumPhases; ph++) begin
			write_reg(CFG_COLOR_MODE, 8'($urandom_range(0, 1)));
			write_reg(CFG_DOM_MARGIN, pick_byte());
			write_reg(CFG_PEAK_MARGIN, (ph % 3 == 0) ? 8'($urandom_range(150, 230)) : pick_byte());
			write_reg(CFG_LEVEL_OFFSET, pick_byte());
			write_reg(CFG_REFRESH_PER, pick_period());
			case ($urandom_range(0, 2))
				0: fe_pct = 3;
				1: fe_pct = 12;
				default: fe_pct = 40;
			endcase
			calm = (ph == 3);
			for (int k = 0; k < PhaseItems; k++) begin
				// hold off the sender until the pipe is empty
				if (ph == 5 && k == PhaseItems / 2) begin
					pix_ch.valid <= 1'b0;
					while (pending_masks.size() != 0) @(posedge clk);
				end
				px = rand_pixel(fe_pct);
				send_pixel(px, 1'b0, 1'b0);
			end
			calm = 1'b0;
		end

		// Drain and settle
		pix_ch.valid <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
